/* rtl/core/cle_pkg.sv */
// Shared types, constants and the shell offset table for the cell list neighbor enumerator.
`timescale 1ns / 1ps

package cle_pkg;

  // Grid limits and field widths
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned INDEX_W   = 24;
  localparam int unsigned PROD_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [SIZE_W-1:0] MAX_CELLS_PER_AXIS = 9'd256;

  // Shell sizes
  localparam int unsigned HALF_SHELL_CELLS = 14;
  localparam int unsigned FULL_SHELL_CELLS = 27;
  localparam int unsigned SHELL_W          = $clog2(FULL_SHELL_CELLS);

  // Request queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE_X = 2'd0,
    CFG_GRID_SIZE_Y = 2'd1,
    CFG_GRID_SIZE_Z = 2'd2,
    CFG_FULL_SHELL  = 2'd3
  } cfg_index_e;

  // Per-axis neighbor step
  typedef enum logic [1:0] {
    OFF_NEG  = 2'd0,
    OFF_ZERO = 2'd1,
    OFF_POS  = 2'd2
  } offset_code_e;

  typedef struct packed {
    offset_code_e dx;
    offset_code_e dy;
    offset_code_e dz;
  } offset_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
  } query_t;

  typedef struct packed {
    logic [INDEX_W-1:0] neighbor_index;
    logic               last_neighbor;
    logic               coord_error;
  } result_t;

  // Effective (saturated) configuration seen by the front
  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic              full_shell;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic                        coord_error;
    logic [FULL_SHELL_CELLS-1:0] neighbor_mask;
    logic [INDEX_W-1:0]          base_index;
    logic [SIZE_W-1:0]           size_x;
    logic [PROD_W-1:0]           size_xy;
  } job_t;

  // Queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Clamp a grid size register to the supported axis length
  function automatic logic [SIZE_W-1:0] saturate_size(input logic [SIZE_W-1:0] size);
    return (size > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : size;
  endfunction

  // Neighbor offsets: self, 13 forward cells, then the 13 backward cells
  function automatic offset_t shell_offset(input logic [SHELL_W-1:0] k);
    offset_t o;
    case (k)
      5'd0:    o = '{OFF_ZERO, OFF_ZERO, OFF_ZERO};
      5'd1:    o = '{OFF_POS,  OFF_ZERO, OFF_ZERO};
      5'd2:    o = '{OFF_ZERO, OFF_POS,  OFF_ZERO};
      5'd3:    o = '{OFF_ZERO, OFF_ZERO, OFF_POS };
      5'd4:    o = '{OFF_POS,  OFF_POS,  OFF_ZERO};
      5'd5:    o = '{OFF_POS,  OFF_ZERO, OFF_POS };
      5'd6:    o = '{OFF_ZERO, OFF_POS,  OFF_POS };
      5'd7:    o = '{OFF_POS,  OFF_NEG,  OFF_ZERO};
      5'd8:    o = '{OFF_NEG,  OFF_ZERO, OFF_POS };
      5'd9:    o = '{OFF_ZERO, OFF_NEG,  OFF_POS };
      5'd10:   o = '{OFF_POS,  OFF_POS,  OFF_POS };
      5'd11:   o = '{OFF_NEG,  OFF_POS,  OFF_POS };
      5'd12:   o = '{OFF_POS,  OFF_NEG,  OFF_POS };
      5'd13:   o = '{OFF_NEG,  OFF_NEG,  OFF_POS };
      5'd14:   o = '{OFF_NEG,  OFF_ZERO, OFF_ZERO};
      5'd15:   o = '{OFF_ZERO, OFF_NEG,  OFF_ZERO};
      5'd16:   o = '{OFF_ZERO, OFF_ZERO, OFF_NEG };
      5'd17:   o = '{OFF_NEG,  OFF_NEG,  OFF_ZERO};
      5'd18:   o = '{OFF_NEG,  OFF_ZERO, OFF_NEG };
      5'd19:   o = '{OFF_ZERO, OFF_NEG,  OFF_NEG };
      5'd20:   o = '{OFF_NEG,  OFF_POS,  OFF_ZERO};
      5'd21:   o = '{OFF_POS,  OFF_ZERO, OFF_NEG };
      5'd22:   o = '{OFF_ZERO, OFF_POS,  OFF_NEG };
      5'd23:   o = '{OFF_NEG,  OFF_NEG,  OFF_NEG };
      5'd24:   o = '{OFF_POS,  OFF_NEG,  OFF_NEG };
      5'd25:   o = '{OFF_NEG,  OFF_POS,  OFF_NEG };
      5'd26:   o = '{OFF_POS,  OFF_POS,  OFF_NEG };
      default: o = '{OFF_ZERO, OFF_ZERO, OFF_ZERO};
    endcase
    return o;
  endfunction

  // True when a step along one axis stays inside the grid
  function automatic logic axis_ok(input offset_code_e code, input logic lo_ok,
                                   input logic hi_ok);
    logic ok;
    case (code)
      OFF_NEG:  ok = lo_ok;
      OFF_ZERO: ok = 1'b1;
      OFF_POS:  ok = hi_ok;
      default:  ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

/* rtl/core/cle_fifo.sv */
// Two-entry request queue between the classifying front and the enumerating back.
`timescale 1ns / 1ps

module cle_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  cle_pkg::job_t         data_i,
  input  logic                  pop_i,
  output cle_pkg::job_t         data_o,
  output cle_pkg::fifo_status_t status_o
);

  cle_pkg::job_t                       mem_q [cle_pkg::FIFO_DEPTH];
  logic [cle_pkg::FIFO_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [cle_pkg::FIFO_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [cle_pkg::FIFO_CNT_W-1:0]      count_q, count_d;

  // Flag full and empty
  assign status_o.full  = (count_q == cle_pkg::FIFO_CNT_W'(cle_pkg::FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!status_o.full || pop_i))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("request queue underflow");

endmodule

/* rtl/core/cle_front.sv */
// Front end: accepts a query, checks it against the grid and builds the base index and shell mask.
`timescale 1ns / 1ps

module cle_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  cle_pkg::query_t       query_i,
  input  cle_pkg::cfg_t         cfg_i,
  input  cle_pkg::fifo_status_t fifo_status_i,
  output logic                  busy_o,
  output logic                  push_o,
  output cle_pkg::job_t         job_o
);

  // Stage A: bounds flags and partial products
  logic                          a_valid_q, a_valid_d;
  logic                          a_error_q;
  logic                          a_full_shell_q;
  logic [cle_pkg::COORD_W-1:0]   a_cx_q;
  logic [cle_pkg::SIZE_W-1:0]    a_sx_q;
  logic [cle_pkg::PROD_W-1:0]    a_zy_q;
  logic [cle_pkg::PROD_W-1:0]    a_yx_q;
  logic [cle_pkg::PROD_W-1:0]    a_xy_q;
  logic                          a_xlo_q, a_xhi_q;
  logic                          a_ylo_q, a_yhi_q;
  logic                          a_zlo_q, a_zhi_q;

  // Stage B: finished request
  logic                          b_valid_q, b_valid_d;
  cle_pkg::job_t                 b_job_q, b_job_d;

  logic                          accept;
  logic                          a_adv;
  logic                          b_push;
  logic [2*cle_pkg::SIZE_W-1:0]  xy_full;
  logic [25:0]                   base_full;
  cle_pkg::offset_t              off;

  // Hand off and stall
  assign b_push = b_valid_q && !fifo_status_i.full;
  assign a_adv  = !b_valid_q || b_push;
  assign busy_o = a_valid_q && !a_adv;
  assign accept = start_i && !busy_o;
  assign push_o = b_push;
  assign job_o  = b_job_q;

  assign xy_full = (2*cle_pkg::SIZE_W)'(cfg_i.size_x) * (2*cle_pkg::SIZE_W)'(cfg_i.size_y);

  // Valid bits for both stages
  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
    b_valid_d = b_valid_q;
    if (a_valid_q && a_adv) begin
      b_valid_d = 1'b1;
    end else if (b_push) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // Capture the query with its bounds flags and products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_error_q      <= ({1'b0, query_i.cell_x} >= cfg_i.size_x) ||
                        ({1'b0, query_i.cell_y} >= cfg_i.size_y) ||
                        ({1'b0, query_i.cell_z} >= cfg_i.size_z);
      a_full_shell_q <= cfg_i.full_shell;
      a_cx_q         <= query_i.cell_x;
      a_sx_q         <= cfg_i.size_x;
      a_zy_q         <= cle_pkg::PROD_W'(query_i.cell_z) * cle_pkg::PROD_W'(cfg_i.size_y);
      a_yx_q         <= cle_pkg::PROD_W'(query_i.cell_y) * cle_pkg::PROD_W'(cfg_i.size_x);
      a_xy_q         <= xy_full[cle_pkg::PROD_W-1:0];
      a_xlo_q        <= (query_i.cell_x != '0);
      a_ylo_q        <= (query_i.cell_y != '0);
      a_zlo_q        <= (query_i.cell_z != '0);
      a_xhi_q        <= (({1'b0, query_i.cell_x} + 9'd1) < cfg_i.size_x);
      a_yhi_q        <= (({1'b0, query_i.cell_y} + 9'd1) < cfg_i.size_y);
      a_zhi_q        <= (({1'b0, query_i.cell_z} + 9'd1) < cfg_i.size_z);
    end
  end

  // Build base index and mask of in-grid neighbors
  always_comb begin
    off       = '{cle_pkg::OFF_ZERO, cle_pkg::OFF_ZERO, cle_pkg::OFF_ZERO};
    base_full = 26'(a_zy_q) * 26'(a_sx_q) + 26'(a_yx_q) + 26'(a_cx_q);
    b_job_d.coord_error = a_error_q;
    b_job_d.base_index  = base_full[cle_pkg::INDEX_W-1:0];
    b_job_d.size_x      = a_sx_q;
    b_job_d.size_xy     = a_xy_q;
    for (int k = 0; k < cle_pkg::FULL_SHELL_CELLS; k++) begin
      off = cle_pkg::shell_offset(cle_pkg::SHELL_W'(k));
      b_job_d.neighbor_mask[k] = cle_pkg::axis_ok(off.dx, a_xlo_q, a_xhi_q) &&
                                 cle_pkg::axis_ok(off.dy, a_ylo_q, a_yhi_q) &&
                                 cle_pkg::axis_ok(off.dz, a_zlo_q, a_zhi_q) &&
                                 ((k < cle_pkg::HALF_SHELL_CELLS) || a_full_shell_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && a_adv) begin
      b_job_q <= b_job_d;
    end
  end

  a_busy_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (a_valid_q && b_valid_q && fifo_status_i.full))
    else $error("front busy while a stage is free");

endmodule

/* rtl/core/cle_back.sv */
// Back end: walks the shell mask of one request and emits one neighbor index per cycle.
`timescale 1ns / 1ps

module cle_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cle_pkg::fifo_status_t fifo_status_i,
  input  cle_pkg::job_t         job_i,
  output logic                  pop_o,
  output logic                  result_valid_o,
  output cle_pkg::result_t      result_o
);

  logic                                cur_valid_q, cur_valid_d;
  cle_pkg::job_t                       cur_q, cur_d;
  logic                                result_valid_q;
  cle_pkg::result_t                    result_q, result_d;

  logic [cle_pkg::SHELL_W-1:0]          sel;
  logic [cle_pkg::FULL_SHELL_CELLS-1:0] sel_onehot;
  logic [cle_pkg::FULL_SHELL_CELLS-1:0] rest;
  logic                                last;
  logic                                done;
  cle_pkg::offset_t                    off;
  logic [cle_pkg::INDEX_W-1:0]          term_x, term_y, term_z;

  // Pick the lowest pending neighbor
  always_comb begin
    sel = '0;
    for (int i = cle_pkg::FULL_SHELL_CELLS - 1; i >= 0; i--) begin
      if (cur_q.neighbor_mask[i]) begin
        sel = cle_pkg::SHELL_W'(i);
      end
    end
  end

  assign sel_onehot = cle_pkg::FULL_SHELL_CELLS'(1) << sel;
  assign rest       = cur_q.neighbor_mask & ~sel_onehot;
  assign last       = (rest == '0);
  assign off        = cle_pkg::shell_offset(sel);

  // Step terms, added modulo the index width
  always_comb begin
    case (off.dx)
      cle_pkg::OFF_POS: term_x = cle_pkg::INDEX_W'(1);
      cle_pkg::OFF_NEG: term_x = '1;
      default:          term_x = '0;
    endcase
    case (off.dy)
      cle_pkg::OFF_POS: term_y = cle_pkg::INDEX_W'(cur_q.size_x);
      cle_pkg::OFF_NEG: term_y = '0 - cle_pkg::INDEX_W'(cur_q.size_x);
      default:          term_y = '0;
    endcase
    case (off.dz)
      cle_pkg::OFF_POS: term_z = cle_pkg::INDEX_W'(cur_q.size_xy);
      cle_pkg::OFF_NEG: term_z = '0 - cle_pkg::INDEX_W'(cur_q.size_xy);
      default:          term_z = '0;
    endcase
  end

  // Form the result and decide when the request is finished
  always_comb begin
    done = cur_valid_q && (cur_q.coord_error || last);
    if (cur_q.coord_error) begin
      result_d.neighbor_index = '0;
      result_d.last_neighbor  = 1'b1;
      result_d.coord_error    = 1'b1;
    end else begin
      result_d.neighbor_index = cur_q.base_index + term_x + term_y + term_z;
      result_d.last_neighbor  = last;
      result_d.coord_error    = 1'b0;
    end
  end

  // Load the next request or drop the emitted neighbor
  assign pop_o = (!cur_valid_q || done) && !fifo_status_i.empty;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      cur_d       = job_i;
    end else if (done) begin
      cur_valid_d = 1'b0;
    end else if (cur_valid_q) begin
      cur_d.neighbor_mask = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q    <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      cur_valid_q    <= cur_valid_d;
      result_valid_q <= cur_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cur_valid_q) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && result_q.coord_error) |-> result_q.last_neighbor)
    else $error("error result not marked last");

  a_mask_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && !cur_q.coord_error) |-> (cur_q.neighbor_mask != '0))
    else $error("active request has no pending neighbor");

endmodule

/* rtl/core/cell_list_neighbor_enumerator.sv */
// Top level of the cell list neighbor enumerator: configuration registers and block wiring.
//
// Usage: write grid_size_x/y/z (index 0..2) and full_shell (index 3) over the
// cfg_valid_i / cfg_ready_o channel while no request is in flight; cfg_ready_o
// is always high. A request carries one cell coordinate and is taken at a
// rising edge with start_i high and busy_o low. Each request yields its
// neighbor cell indices on result_o, one per cycle, each marked by a
// one-cycle result_valid_o; the final one has last_neighbor set. A coordinate
// outside the grid gives a single result with coord_error set.
// Path: an accepted request passes the two front stages (A and B) and the queue,
// then the back end's current request register; each result leaves the output register.
// Throughput: one result per cycle while a request is in the back end; a request
// has 1 to 14 results in half shell, 1 to 27 in full shell. The back end loads
// the next queued request as the last one forms its final result, so requests
// back to back give results with no gap. The front and a two-entry queue buffer
// up to four requests, after which busy_o holds off start_i until the back end frees an entry.
// Reset: grid sizes return to 1, full_shell to 0, all requests are dropped.
// The receiver cannot stall: every result is taken in its strobe cycle.
`timescale 1ns / 1ps

module cell_list_neighbor_enumerator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  cle_pkg::query_t                    query_i,
  output logic                               busy_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cle_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cle_pkg::SIZE_W-1:0]         cfg_data_i,
  output logic                               result_valid_o,
  output cle_pkg::result_t                   result_o
);

  logic [cle_pkg::SIZE_W-1:0] grid_size_x_q;
  logic [cle_pkg::SIZE_W-1:0] grid_size_y_q;
  logic [cle_pkg::SIZE_W-1:0] grid_size_z_q;
  logic                       full_shell_q;

  cle_pkg::cfg_t              cfg;
  cle_pkg::fifo_status_t      fifo_status;
  cle_pkg::job_t              push_job;
  cle_pkg::job_t              pop_job;
  logic                       fifo_push;
  logic                       fifo_pop;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_x_q <= cle_pkg::SIZE_W'(1);
      grid_size_y_q <= cle_pkg::SIZE_W'(1);
      grid_size_z_q <= cle_pkg::SIZE_W'(1);
      full_shell_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cle_pkg::cfg_index_e'(cfg_index_i))
        cle_pkg::CFG_GRID_SIZE_X: grid_size_x_q <= cfg_data_i;
        cle_pkg::CFG_GRID_SIZE_Y: grid_size_y_q <= cfg_data_i;
        cle_pkg::CFG_GRID_SIZE_Z: grid_size_z_q <= cfg_data_i;
        cle_pkg::CFG_FULL_SHELL:  full_shell_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to the supported axis length
  assign cfg.size_x     = cle_pkg::saturate_size(grid_size_x_q);
  assign cfg.size_y     = cle_pkg::saturate_size(grid_size_y_q);
  assign cfg.size_z     = cle_pkg::saturate_size(grid_size_z_q);
  assign cfg.full_shell = full_shell_q;

  cle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .query_i       (query_i),
    .cfg_i         (cfg),
    .fifo_status_i (fifo_status),
    .busy_o        (busy_o),
    .push_o        (fifo_push),
    .job_o         (push_job)
  );

  cle_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fifo_push),
    .data_i   (push_job),
    .pop_i    (fifo_pop),
    .data_o   (pop_job),
    .status_o (fifo_status)
  );

  cle_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_status_i  (fifo_status),
    .job_i          (pop_job),
    .pop_o          (fifo_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the cell list neighbor enumerator.
`timescale 1ns / 1ps

module tb;

  localparam int CLOCK_HALF    = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_QUERIES = 32;
  localparam int PRINT_CAP     = 50;
  localparam int AXIS_CAP      = int'(cle_pkg::MAX_CELLS_PER_AXIS);

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          start_i     = 1'b0;
  cle_pkg::query_t               query_i     = '0;
  logic                          busy_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [cle_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [cle_pkg::SIZE_W-1:0]    cfg_data_i  = '0;
  logic                          result_valid_o;
  cle_pkg::result_t              result_o;

  // Neighbor steps per axis: self, 13 forward cells, 13 backward cells
  int step_x [cle_pkg::FULL_SHELL_CELLS] = '{0, 1, 0, 0, 1, 1, 0, 1, -1, 0, 1, -1, 1, -1,
                                    -1, 0, 0, -1, -1, 0, -1, 1, 0, -1, 1, -1, 1};
  int step_y [cle_pkg::FULL_SHELL_CELLS] = '{0, 0, 1, 0, 1, 0, 1, -1, 0, -1, 1, 1, -1, -1,
                                    0, -1, 0, -1, 0, -1, 1, 0, 1, -1, -1, 1, 1};
  int step_z [cle_pkg::FULL_SHELL_CELLS] = '{0, 0, 0, 1, 0, 1, 1, 0, 1, 1, 1, 1, 1, 1,
                                    0, 0, -1, 0, -1, -1, 0, -1, -1, -1, -1, -1, -1};

  // Grid settings as last written (reset values until then)
  int      grid_x          = 1;
  int      grid_y          = 1;
  int      grid_z          = 1;
  bit      full_shell_mode = 1'b0;

  cle_pkg::query_t  pending_queries[$];
  cle_pkg::result_t expected_neighbors[$];
  cle_pkg::result_t want_result;
  bit      holding_query    = 1'b0;
  int      sender_idle_pct  = 0;
  int      mismatches       = 0;
  int      accepted_queries = 0;
  int      checked_results  = 0;
  int      oob_queries      = 0;
  int      grid_settings    = 0;
  int      cycle_count      = 0;

  cell_list_neighbor_enumerator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .query_i        (query_i),
    .busy_o         (busy_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #CLOCK_HALF clk_i = ~clk_i;

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Expand one query into its neighbor indices under the current grid
  function automatic void enumerate_neighbors(input cle_pkg::query_t q);
    int      sx, sy, sz, cx, cy, cz, nx, ny, nz, cells, idx;
    cle_pkg::result_t r;
    cle_pkg::result_t found[$];
    sx = (grid_x > AXIS_CAP) ? AXIS_CAP : grid_x;
    sy = (grid_y > AXIS_CAP) ? AXIS_CAP : grid_y;
    sz = (grid_z > AXIS_CAP) ? AXIS_CAP : grid_z;
    cx = int'(q.cell_x);
    cy = int'(q.cell_y);
    cz = int'(q.cell_z);
    // Out-of-grid query: one flagged result, index zero
    if (cx >= sx || cy >= sy || cz >= sz) begin
      r.neighbor_index = '0;
      r.last_neighbor  = 1'b1;
      r.coord_error    = 1'b1;
      expected_neighbors = {expected_neighbors, r};
      oob_queries++;
      return;
    end
    cells = full_shell_mode ? int'(cle_pkg::FULL_SHELL_CELLS) :
                              int'(cle_pkg::HALF_SHELL_CELLS);
    for (int k = 0; k < cells; k++) begin
      nx = cx + step_x[k];
      ny = cy + step_y[k];
      nz = cz + step_z[k];
      if (nx < 0 || nx >= sx || ny < 0 || ny >= sy || nz < 0 || nz >= sz) continue;
      idx = nz * sx * sy + ny * sx + nx;
      r.neighbor_index = idx[cle_pkg::INDEX_W-1:0];
      r.last_neighbor  = 1'b0;
      r.coord_error    = 1'b0;
      found = {found, r};
    end
    // Mark the final neighbor; the self cell guarantees at least one
    r = found.pop_back();
    r.last_neighbor = 1'b1;
    found = {found, r};
    expected_neighbors = {expected_neighbors, found};
  endfunction

  // Present queued requests, holding each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i       <= 1'b0;
      query_i       <= '0;
      holding_query = 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        enumerate_neighbors(query_i);
        accepted_queries++;
        holding_query = 1'b0;
      end
      if (!holding_query && pending_queries.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        query_i       <= pending_queries.pop_front();
        start_i       <= 1'b1;
        holding_query = 1'b1;
      end else if (!holding_query) begin
        start_i <= 1'b0;
      end
    end
  end

  // Check each strobed result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      if (expected_neighbors.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: index %0d last %b error %b",
                                  result_o.neighbor_index, result_o.last_neighbor,
                                  result_o.coord_error));
      end else begin
        want_result = expected_neighbors.pop_front();
        if (result_o.neighbor_index !== want_result.neighbor_index)
          report_mismatch($sformatf("neighbor_index %0d, want %0d",
                                    result_o.neighbor_index, want_result.neighbor_index));
        if (result_o.last_neighbor !== want_result.last_neighbor)
          report_mismatch($sformatf("last_neighbor %b, want %b (index %0d)",
                                    result_o.last_neighbor, want_result.last_neighbor,
                                    want_result.neighbor_index));
        if (result_o.coord_error !== want_result.coord_error)
          report_mismatch($sformatf("coord_error %b, want %b (index %0d)",
                                    result_o.coord_error, want_result.coord_error,
                                    want_result.neighbor_index));
        checked_results++;
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_neighbors.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Wait until every request is taken and every result has arrived
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_queries.size() != 0 || holding_query || expected_neighbors.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register over the config channel and track it
  task automatic write_register(input cle_pkg::cfg_index_e sel,
                                input logic [cle_pkg::SIZE_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (sel)
      cle_pkg::CFG_GRID_SIZE_X: grid_x = int'(value);
      cle_pkg::CFG_GRID_SIZE_Y: grid_y = int'(value);
      cle_pkg::CFG_GRID_SIZE_Z: grid_z = int'(value);
      cle_pkg::CFG_FULL_SHELL:  full_shell_mode = value[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Drain, then load a new grid shape and shell mode
  task automatic apply_grid(input int sx, input int sy, input int sz,
                            input logic [cle_pkg::SIZE_W-1:0] shell_word);
    wait_drained();
    write_register(cle_pkg::CFG_GRID_SIZE_X, cle_pkg::SIZE_W'(sx));
    write_register(cle_pkg::CFG_GRID_SIZE_Y, cle_pkg::SIZE_W'(sy));
    write_register(cle_pkg::CFG_GRID_SIZE_Z, cle_pkg::SIZE_W'(sz));
    write_register(cle_pkg::CFG_FULL_SHELL, shell_word);
    grid_settings++;
  endtask

  task automatic queue_query(input int x, input int y, input int z);
    cle_pkg::query_t q;
    q.cell_x = cle_pkg::COORD_W'(x);
    q.cell_y = cle_pkg::COORD_W'(y);
    q.cell_z = cle_pkg::COORD_W'(z);
    pending_queries = {pending_queries, q};
  endtask

  // Mostly small grids, some full-size, some above the axis limit and some of size zero
  function automatic int pick_grid_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)  return 0;
    if (roll < 30) return $urandom_range(1, 3);
    if (roll < 70) return $urandom_range(4, 12);
    if (roll < 85) return $urandom_range(13, 256);
    if (roll < 93) return 256;
    return $urandom_range(257, 511);
  endfunction

  // Favor edges of the grid, with some coordinates anywhere in range
  function automatic int pick_coord(input int size);
    int eff, roll;
    eff  = (size > AXIS_CAP) ? AXIS_CAP : size;
    roll = $urandom_range(0, 99);
    if (eff == 0 || roll < 8) return $urandom_range(0, 255);
    if (roll < 30) return $urandom_range(0, 1) ? 0 : eff - 1;
    return $urandom_range(0, eff - 1);
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct = 29;

    // Reset grid of one cell: self only, then out-of-grid queries
    queue_query(0, 0, 0);
    queue_query(0, 0, 1);
    queue_query(255, 0, 0);

    // Small full-shell box: corners, interior, each axis just outside
    apply_grid(4, 5, 6, 9'd1);
    queue_query(0, 0, 0);
    queue_query(3, 4, 5);
    queue_query(1, 2, 3);
    queue_query(3, 0, 5);
    queue_query(4, 0, 0);
    queue_query(0, 5, 0);
    queue_query(0, 0, 6);

    // Largest grid, half shell
    apply_grid(256, 256, 256, 9'd0);
    queue_query(255, 255, 255);
    queue_query(0, 0, 0);
    queue_query(170, 85, 42);

    // Sizes above the axis limit saturate
    apply_grid(511, 300, 257, 9'd1);
    queue_query(255, 255, 255);
    queue_query(0, 255, 128);
    queue_query(100, 0, 255);

    // Zero-size axis: every query is out of grid
    apply_grid(0, 3, 3, 9'd1);
    queue_query(0, 0, 0);
    queue_query(0, 1, 1);

    // Flat and single-cell grids in full shell
    apply_grid(2, 1, 3, 9'd1);
    queue_query(1, 0, 1);
    queue_query(0, 0, 0);
    queue_query(1, 1, 1);
    apply_grid(1, 1, 1, 9'd1);
    queue_query(0, 0, 0);

    // Random grids and queries; pause for a full drain halfway through each
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      int sx, sy, sz;
      sx = pick_grid_size();
      sy = pick_grid_size();
      sz = pick_grid_size();
      apply_grid(sx, sy, sz, cle_pkg::SIZE_W'($urandom_range(0, 511)));
      sender_idle_pct = (phase < 3) ? 29 : ((phase < 6) ? 84 : 0);
      for (int n = 0; n < PHASE_QUERIES; n++) begin
        if (n == PHASE_QUERIES / 2) wait_drained();
        queue_query(pick_coord(sx), pick_coord(sy), pick_coord(sz));
      end
    end

    wait_drained();
    $display("Checked %0d neighbor results from %0d queries (%0d outside the grid)",
             checked_results, accepted_queries, oob_queries);
    $display("across %0d grid settings in both shell modes, with and without sender gaps",
             grid_settings);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
